>>> sv/rtff_pkg.sv
// Shared types and defaults for the range table first-fit allocator.
// Holds the request and response structs and the request kind codes.
// No dependencies.
package rtff_pkg;

  localparam int TABLE_ENTRIES_DEF = 128;
  localparam int ADDR_WIDTH_DEF    = 64;

  typedef enum logic [1:0] {
    REQ_ADD_MEM = 2'd0,
    REQ_RESERVE = 2'd1,
    REQ_ALLOC   = 2'd2,
    REQ_QUERY   = 2'd3
  } req_kind_t;

  typedef struct packed {
    req_kind_t   req_type;
    logic [63:0] range_begin;
    logic [63:0] range_end;
    logic [63:0] alloc_size;
    logic [31:0] alloc_align;
    logic [63:0] window_from;
    logic [63:0] window_to;
  } req_t;

  typedef struct packed {
    logic        status;
    logic [63:0] address;
    logic        range_free;
  } rsp_t;

endpackage

>>> sv/rtff_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Used for both range tables. No dependencies.
module rtff_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] store [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      store[waddr] <= wdata;
    end
    rdata <= store[raddr];
  end

endmodule

>>> sv/range_table_first_fit_allocator_top.sv
// Range table first-fit allocator: sorted memory and reservation tables in RAM.
// An empty or inverted query and an empty insert answer without touching the tables; an
// allocate walks the memory entries, skipping reservations below the cursor and hopping
// past overlapping ones, then inserts the block into the reservation table.
// Throughput: one request at a time; the next is taken once the result is latched.
// Reset: rst (synchronous) clears both counts and the control state; RAMs keep data.
module range_table_first_fit_allocator_top #(
  parameter int TABLE_ENTRIES = rtff_pkg::TABLE_ENTRIES_DEF,
  parameter int ADDR_WIDTH    = rtff_pkg::ADDR_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  rtff_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output rtff_pkg::rsp_t rsp
);

  import rtff_pkg::*;

  localparam int AW = ADDR_WIDTH;
  localparam int N  = TABLE_ENTRIES;
  localparam int CW = $clog2(N + 1);
  localparam int IW = $clog2(N);
  localparam int NS = 21;

  // One-hot sequencer states
  typedef enum logic [NS-1:0] {
    S_IDLE  = 21'd1 << 0,
    S_FINIT = 21'd1 << 1,   // window sanity checks
    S_MRD   = 21'd1 << 2,   // issue memory-table read
    S_MCHK  = 21'd1 << 3,   // clip memory range to window
    S_C1    = 21'd1 << 4,   // round cursor up to alignment
    S_C2    = 21'd1 << 5,   // check block fits under limit
    S_RRD   = 21'd1 << 6,   // issue reservation read
    S_RCHK  = 21'd1 << 7,   // test block against reservation
    S_FDONE = 21'd1 << 8,   // search result
    S_ADD0  = 21'd1 << 9,   // insert: empty range check
    S_ARD   = 21'd1 << 10,  // insert: scan read
    S_ACHK  = 21'd1 << 11,  // insert: scan compare
    S_MGRD  = 21'd1 << 12,  // merge: read successor
    S_MGCHK = 21'd1 << 13,  // merge: absorb successor
    S_MGWR  = 21'd1 << 14,  // merge: write merged entry
    S_CPRD  = 21'd1 << 15,  // compaction read
    S_CPWR  = 21'd1 << 16,  // compaction write
    S_INS0  = 21'd1 << 17,  // insert: full check
    S_INRD  = 21'd1 << 18,  // insert shift read / final write
    S_INWR  = 21'd1 << 19,  // insert shift write
    S_OUT   = 21'd1 << 20   // hand result to output register
  } state_t;

  state_t state;

  // Request registers
  req_kind_t      kind;
  logic           sel_resv;   // table targeted by the insert engine
  logic [AW-1:0]  b, e;       // range being inserted
  logic [AW-1:0]  size, amask, from, to;
  logic [AW-1:0]  cur, lim, curend;
  logic [CW-1:0]  mi, rj;     // walk indexes: memory, reservations
  logic [CW-1:0]  i, j, k, w; // insert engine indexes
  logic [AW-1:0]  cb, ce;     // merged entry
  logic [CW-1:0]  mem_count, resv_count;

  // Result registers
  logic           st;
  logic [AW-1:0]  res_addr;
  logic           freeb;

  // RAM ports (both tables share the read address)
  logic [IW-1:0]   raddr, waddr;
  logic            wr_en;
  logic [2*AW-1:0] wdata;
  logic [2*AW-1:0] mem_rdata, resv_rdata, rdata_sel;

  logic [AW-1:0] mb, me, rb, re, tb, te;
  logic [CW-1:0] n;
  logic [CW-1:0] km1;
  logic [AW:0]   sum_c;

  // Incoming fields cut to the address width
  logic [AW-1:0] in_rb, in_re, in_size, in_from, in_to;
  logic [31:0]   a32, am32;
  logic [AW+31:0] am_ext;

  assign in_rb   = req.range_begin[AW-1:0];
  assign in_re   = req.range_end[AW-1:0];
  assign in_size = req.alloc_size[AW-1:0];
  assign in_from = req.window_from[AW-1:0];
  assign in_to   = req.window_to[AW-1:0];

  // Lowest set bit of the alignment; zero counts as one
  always_comb begin
    a32 = req.alloc_align & (~req.alloc_align + 32'd1);
    if (a32 == 32'd0) begin
      a32 = 32'd1;
    end
    am32   = a32 - 32'd1;
    am_ext = {{AW{1'b0}}, am32};
  end

  assign mb = mem_rdata[2*AW-1:AW];
  assign me = mem_rdata[AW-1:0];
  assign rb = resv_rdata[2*AW-1:AW];
  assign re = resv_rdata[AW-1:0];
  assign rdata_sel = sel_resv ? resv_rdata : mem_rdata;
  assign tb = rdata_sel[2*AW-1:AW];
  assign te = rdata_sel[AW-1:0];
  assign n  = sel_resv ? resv_count : mem_count;
  assign km1 = k - CW'(1);
  assign sum_c = {1'b0, cur} + {1'b0, amask};

  assign req_ready = (state == S_IDLE);

  // RAM address and write control
  always_comb begin
    raddr = '0;
    waddr = '0;
    wr_en = 1'b0;
    wdata = '0;
    unique case (state)
      S_MRD:  raddr = mi[IW-1:0];
      S_RRD:  raddr = rj[IW-1:0];
      S_ARD:  raddr = i[IW-1:0];
      S_MGRD: raddr = j[IW-1:0];
      S_CPRD: raddr = k[IW-1:0];
      S_MGWR: begin
        wr_en = 1'b1;
        waddr = i[IW-1:0];
        wdata = {cb, ce};
      end
      S_CPWR: begin
        wr_en = 1'b1;
        waddr = w[IW-1:0];
        wdata = rdata_sel;
      end
      S_INRD: begin
        if (k > i) begin
          raddr = km1[IW-1:0];
        end else begin
          wr_en = 1'b1;
          waddr = i[IW-1:0];
          wdata = {b, e};
        end
      end
      S_INWR: begin
        wr_en = 1'b1;
        waddr = k[IW-1:0];
        wdata = rdata_sel;
      end
      default: ;
    endcase
  end

  rtff_ram #(.WIDTH(2 * AW), .DEPTH(N)) u_mem_ram (
    .clk   (clk),
    .we    (wr_en && !sel_resv),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (mem_rdata)
  );

  rtff_ram #(.WIDTH(2 * AW), .DEPTH(N)) u_resv_ram (
    .clk   (clk),
    .we    (wr_en && sel_resv),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (resv_rdata)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      mem_count  <= '0;
      resv_count <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      // output state handles its own transfer
      if (rsp_valid && rsp_ready && state != S_OUT) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            kind     <= req.req_type;
            st       <= 1'b0;
            res_addr <= '0;
            freeb    <= 1'b0;
            b        <= in_rb;
            e        <= in_re;
            unique case (req.req_type)
              REQ_ADD_MEM: begin
                sel_resv <= 1'b0;
                state    <= S_ADD0;
              end
              REQ_RESERVE: begin
                sel_resv <= 1'b1;
                state    <= S_ADD0;
              end
              REQ_ALLOC: begin
                size  <= in_size;
                from  <= in_from;
                to    <= in_to;
                amask <= am_ext[AW-1:0];
                state <= S_FINIT;
              end
              REQ_QUERY: begin
                size  <= in_re - in_rb;
                from  <= in_rb;
                to    <= in_re;
                amask <= '0;
                state <= (in_re > in_rb) ? S_FINIT : S_OUT;
              end
              default: state <= S_OUT;
            endcase
          end
        end

        // First-fit search
        S_FINIT: begin
          mi <= '0;
          rj <= '0;
          if (from > to || size > to - from) begin
            res_addr <= to;
            state    <= S_FDONE;
          end else if (size == '0) begin
            res_addr <= from;
            state    <= S_FDONE;
          end else begin
            state <= S_MRD;
          end
        end
        S_MRD: begin
          if (mi >= mem_count) begin
            res_addr <= to;
            state    <= S_FDONE;
          end else begin
            state <= S_MCHK;
          end
        end
        S_MCHK: begin
          if (me <= from) begin
            mi    <= mi + CW'(1);
            state <= S_MRD;
          end else if (mb >= to) begin
            res_addr <= to;
            state    <= S_FDONE;
          end else begin
            lim   <= (me < to) ? me : to;
            cur   <= (mb > from) ? mb : from;
            state <= S_C1;
          end
        end
        S_C1: begin
          if (cur >= lim || sum_c[AW]) begin
            mi    <= mi + CW'(1);
            state <= S_MRD;
          end else begin
            cur   <= sum_c[AW-1:0] & ~amask;
            state <= S_C2;
          end
        end
        S_C2: begin
          if (cur >= lim || size > lim - cur) begin
            mi    <= mi + CW'(1);
            state <= S_MRD;
          end else begin
            state <= S_RRD;
          end
        end
        S_RRD: begin
          curend <= cur + size;
          if (rj >= resv_count) begin
            res_addr <= cur;
            state    <= S_FDONE;
          end else begin
            state <= S_RCHK;
          end
        end
        S_RCHK: begin
          if (re <= cur) begin
            rj    <= rj + CW'(1);
            state <= S_RRD;
          end else if (rb >= curend) begin
            res_addr <= cur;
            state    <= S_FDONE;
          end else begin
            cur   <= re;
            state <= S_C1;
          end
        end
        S_FDONE: begin
          if (kind == REQ_QUERY) begin
            freeb    <= (res_addr != to);
            res_addr <= '0;
            state    <= S_OUT;
          end else if (res_addr == to) begin
            st    <= 1'b1;
            state <= S_OUT;
          end else begin
            sel_resv <= 1'b1;
            b        <= res_addr;
            e        <= res_addr + size;
            state    <= S_ADD0;
          end
        end

        // Sorted insert with merge
        S_ADD0: begin
          i     <= '0;
          state <= (e <= b) ? S_OUT : S_ARD;
        end
        S_ARD: begin
          state <= (i < n) ? S_ACHK : S_INS0;
        end
        S_ACHK: begin
          if (te < b) begin
            i     <= i + CW'(1);
            state <= S_ARD;
          end else if (tb <= e) begin
            cb    <= (b < tb) ? b : tb;
            ce    <= (e > te) ? e : te;
            j     <= i + CW'(1);
            state <= S_MGRD;
          end else begin
            state <= S_INS0;
          end
        end
        S_MGRD: begin
          state <= (j < n) ? S_MGCHK : S_MGWR;
        end
        S_MGCHK: begin
          if (tb <= ce) begin
            if (te > ce) begin
              ce <= te;
            end
            j     <= j + CW'(1);
            state <= S_MGRD;
          end else begin
            state <= S_MGWR;
          end
        end
        S_MGWR: begin
          k     <= j;
          w     <= i + CW'(1);
          state <= S_CPRD;
        end
        S_CPRD: begin
          if (k < n) begin
            state <= S_CPWR;
          end else begin
            if (sel_resv) begin
              resv_count <= w;
            end else begin
              mem_count <= w;
            end
            state <= S_OUT;
          end
        end
        S_CPWR: begin
          k     <= k + CW'(1);
          w     <= w + CW'(1);
          state <= S_CPRD;
        end
        S_INS0: begin
          if (n >= CW'(N)) begin
            st <= 1'b1;
            if (kind == REQ_ALLOC) begin
              res_addr <= to;
            end
            state <= S_OUT;
          end else begin
            k     <= n;
            state <= S_INRD;
          end
        end
        S_INRD: begin
          if (k > i) begin
            state <= S_INWR;
          end else begin
            if (sel_resv) begin
              resv_count <= n + CW'(1);
            end else begin
              mem_count <= n + CW'(1);
            end
            state <= S_OUT;
          end
        end
        S_INWR: begin
          k     <= km1;
          state <= S_INRD;
        end

        S_OUT: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid      <= 1'b1;
            rsp.status     <= st;
            rsp.address    <= 64'(res_addr);
            rsp.range_free <= freeb;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Table fill never exceeds the RAM depth
  assert property (@(posedge clk) disable iff (rst)
    mem_count <= CW'(N) && resv_count <= CW'(N))
    else $error("table count beyond depth");

  // An accepted transfer always leaves the idle state
  assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (state != S_IDLE))
    else $error("request accepted but sequencer stayed idle");

  // No table write while idle or presenting a result
  assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state != S_IDLE && state != S_OUT))
    else $error("table write outside an insert");

  // Result register is only loaded from the output state
  assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == S_OUT))
    else $error("response raised outside output state");

endmodule
